// ===== rtl/opm_pkg.sv =====
// Shared types, constants and helpers for the oil-paint mode filter.
package opm_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 4096;
   localparam int MAX_RADIUS = 10;

   localparam int RING     = 2 * MAX_RADIUS + 1;
   localparam int RING_W   = $clog2(RING);
   localparam int COL_W    = $clog2(MAX_WIDTH);
   localparam int ROW_W    = $clog2(MAX_HEIGHT);
   localparam int EW_W     = $clog2(MAX_WIDTH + 1);
   localparam int EH_W     = $clog2(MAX_HEIGHT + 1);
   localparam int RAD_W    = $clog2(MAX_RADIUS + 1);
   localparam int WJ_W     = $clog2(2 * MAX_RADIUS + 1);
   localparam int GAP_W    = $clog2(MAX_RADIUS * MAX_WIDTH + 2);
   localparam int LS_DEPTH = RING * MAX_WIDTH;
   localparam int LS_AW    = $clog2(LS_DEPTH);

   localparam int BINS     = 256;
   localparam int BIN_W    = 8;
   localparam int CNT_W    = 8;

   // register fields as written on the config port
   localparam int CFG_W_W  = 11;
   localparam int CFG_H_W  = 13;
   localparam int CFG_R_W  = 4;
   localparam int CSR_DW   = 13;
   localparam int CSR_IW   = 2;

   typedef enum logic [CSR_IW-1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1,
      CSR_WINDOW_RAD   = 2'd2,
      CSR_COLOR_MODE   = 2'd3
   } csr_index_type;

   localparam logic KIND_PIXEL = 1'b0;

   // luminance weights: true colour, then indexed
   localparam logic [11:0] LT_R = 12'd871;
   localparam logic [11:0] LT_G = 12'd2929;
   localparam logic [11:0] LT_B = 12'd295;
   localparam logic [11:0] LI_R = 12'd872;
   localparam logic [11:0] LI_G = 12'd2930;
   localparam logic [11:0] LI_B = 12'd296;
   localparam int LUMA_SHIFT = 12;

   typedef struct packed {
      logic       kind;
      logic [7:0] in_red;
      logic [7:0] in_green;
      logic [7:0] in_blue;
      logic [7:0] in_index;
   } req_type;

   typedef struct packed {
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic [7:0] out_index;
      logic       frame_last;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_CENTRE_RD,
      ST_CENTRE_WAIT,
      ST_VOTE_RD,
      ST_VOTE_LUMA,
      ST_HIST_RD,
      ST_HIST_UPD,
      ST_LOAD,
      ST_CLEAR
   } state_type;

   typedef struct packed {
      logic accept;
      logic walk_init;
      logic centre_rd;
      logic centre_take;
      logic vote_rd;
      logic vote_take;
      logic hist_rd;
      logic hist_upd;
      logic load_out;
      logic clear_step;
   } cmd_type;

   typedef struct packed {
      logic release_ok;
      logic interior;
      logic walk_last;
      logic out_free;
      logic clear_last;
   } status_type;

   function automatic logic [RING_W-1:0] ring_sub(logic [RING_W-1:0] a,
                                                  logic [RAD_W-1:0] d);
      logic [RING_W:0] t;
      t = {1'b0, a} + (RING_W + 1)'(RING) - (RING_W + 1)'(d);
      if (t >= (RING_W + 1)'(RING)) t = t - (RING_W + 1)'(RING);
      return t[RING_W-1:0];
   endfunction

   function automatic logic [RING_W-1:0] ring_add(logic [RING_W-1:0] a,
                                                  logic [RAD_W-1:0] d);
      logic [RING_W:0] t;
      t = {1'b0, a} + (RING_W + 1)'(d);
      if (t >= (RING_W + 1)'(RING)) t = t - (RING_W + 1)'(RING);
      return t[RING_W-1:0];
   endfunction

endpackage

// ===== rtl/opm_ram.sv =====
// Generic simple dual-port RAM with registered read.
module opm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

endmodule

// ===== rtl/opm_ctrl.sv =====
// Sequencer for the oil-paint mode filter.
module opm_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  opm_pkg::status_type  status,
   output opm_pkg::cmd_type     cmd
);

   opm_pkg::state_type state_ff, state_in;

   // reset starts with a sweep of the histogram bins to zero
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= opm_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         opm_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = opm_pkg::ST_DECIDE;
            end
         end
         opm_pkg::ST_DECIDE: begin
            cmd.walk_init = 1'b1;
            priority if (!status.release_ok) begin
               state_in = opm_pkg::ST_IDLE;
            end else if (status.interior) begin
               state_in = opm_pkg::ST_VOTE_RD;
            end else begin
               state_in = opm_pkg::ST_CENTRE_RD;
            end
         end
         opm_pkg::ST_CENTRE_RD: begin
            cmd.centre_rd = 1'b1;
            state_in      = opm_pkg::ST_CENTRE_WAIT;
         end
         opm_pkg::ST_CENTRE_WAIT: begin
            cmd.centre_take = 1'b1;
            state_in        = opm_pkg::ST_LOAD;
         end
         opm_pkg::ST_VOTE_RD: begin
            cmd.vote_rd = 1'b1;
            state_in    = opm_pkg::ST_VOTE_LUMA;
         end
         opm_pkg::ST_VOTE_LUMA: begin
            cmd.vote_take = 1'b1;
            state_in      = opm_pkg::ST_HIST_RD;
         end
         opm_pkg::ST_HIST_RD: begin
            cmd.hist_rd = 1'b1;
            state_in    = opm_pkg::ST_HIST_UPD;
         end
         opm_pkg::ST_HIST_UPD: begin
            cmd.hist_upd = 1'b1;
            state_in = status.walk_last ? opm_pkg::ST_LOAD : opm_pkg::ST_VOTE_RD;
         end
         opm_pkg::ST_LOAD: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in = status.interior ? opm_pkg::ST_CLEAR : opm_pkg::ST_IDLE;
            end
         end
         opm_pkg::ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) begin
               state_in = opm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = opm_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/opm_dp.sv =====
// Datapath: line store, histogram, counters, config and result register.
module opm_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [opm_pkg::CSR_IW-1:0]        csr_index,
   input  logic [opm_pkg::CSR_DW-1:0]        csr_wdata,
   input  opm_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output opm_pkg::rsp_type                  rsp_data,
   input  opm_pkg::cmd_type                  cmd,
   output opm_pkg::status_type               status
);

   localparam int RW = opm_pkg::RING_W;
   localparam int CW = opm_pkg::COL_W;
   localparam int XW = opm_pkg::ROW_W;

   // config
   logic [opm_pkg::CFG_W_W-1:0] cfg_w_ff;
   logic [opm_pkg::CFG_H_W-1:0] cfg_h_ff;
   logic [opm_pkg::CFG_R_W-1:0] cfg_r_ff;
   logic                        cfg_mode_ff;

   // frame counters
   logic [CW-1:0]               in_col_ff, in_col_in;
   logic [XW-1:0]               in_row_ff, in_row_in;
   logic [RW-1:0]               in_ring_ff, in_ring_in;
   logic [CW-1:0]               out_col_ff, out_col_in;
   logic [XW-1:0]               out_row_ff, out_row_in;
   logic [RW-1:0]               out_ring_ff, out_ring_in;
   logic [opm_pkg::GAP_W-1:0]   gap_ff, gap_in;
   logic                        frame_in_ff, frame_in_in;

   // neighbourhood walk
   logic [opm_pkg::RAD_W-1:0]   wi_ff, wi_in;
   logic [opm_pkg::WJ_W-1:0]    wj_ff, wj_in;
   logic                        wlow_ff, wlow_in;
   logic                        wmid_ff, wmid_in;

   logic [31:0]                 word_ff;
   logic [opm_pkg::BIN_W-1:0]   luma_ff;
   logic [opm_pkg::CNT_W-1:0]   best_ff;
   logic [31:0]                 chosen_ff;
   logic [opm_pkg::BIN_W-1:0]   clr_ff;

   logic                        rsp_valid_ff;
   opm_pkg::rsp_type            rsp_ff;

   logic [opm_pkg::EW_W-1:0]    eff_w;
   logic [opm_pkg::EH_W-1:0]    eff_h;
   logic [opm_pkg::RAD_W-1:0]   eff_r;
   logic [opm_pkg::GAP_W-1:0]   span;
   logic                        restart;
   logic                        is_last;
   logic                        px_write;

   logic                        ls_we;
   logic [opm_pkg::LS_AW-1:0]   ls_waddr, ls_raddr;
   logic [31:0]                 ls_wdata, ls_rdata;
   logic [RW-1:0]               v_ring;
   logic [CW:0]                 v_col;
   logic [opm_pkg::RAD_W-1:0]   v_d;
   logic [19:0]                 luma_sum;
   logic [11:0]                 k_r, k_g, k_b;

   logic                        h_we;
   logic [opm_pkg::BIN_W-1:0]   h_waddr;
   logic [opm_pkg::CNT_W-1:0]   h_wdata, h_rdata, h_next;

   // effective geometry
   always_comb begin
      priority if (cfg_w_ff == '0) eff_w = opm_pkg::EW_W'(1);
      else if (32'(cfg_w_ff) > opm_pkg::MAX_WIDTH) eff_w = opm_pkg::EW_W'(opm_pkg::MAX_WIDTH);
      else eff_w = opm_pkg::EW_W'(cfg_w_ff);
      priority if (cfg_h_ff == '0) eff_h = opm_pkg::EH_W'(1);
      else if (32'(cfg_h_ff) > opm_pkg::MAX_HEIGHT) eff_h = opm_pkg::EH_W'(opm_pkg::MAX_HEIGHT);
      else eff_h = opm_pkg::EH_W'(cfg_h_ff);
      priority if (cfg_r_ff < opm_pkg::CFG_R_W'(2)) eff_r = opm_pkg::RAD_W'(2);
      else if (32'(cfg_r_ff) > opm_pkg::MAX_RADIUS) eff_r = opm_pkg::RAD_W'(opm_pkg::MAX_RADIUS);
      else eff_r = opm_pkg::RAD_W'(cfg_r_ff);
   end

   assign span = opm_pkg::GAP_W'(eff_r) * opm_pkg::GAP_W'(eff_w);

   assign status.release_ok = frame_in_ff || (gap_ff > span);
   assign status.interior =
      ((opm_pkg::EH_W + 1)'(out_row_ff) >= (opm_pkg::EH_W + 1)'(eff_r)) &&
      ((opm_pkg::EH_W + 1)'(out_row_ff) + (opm_pkg::EH_W + 1)'(eff_r) <
       (opm_pkg::EH_W + 1)'(eff_h)) &&
      ((opm_pkg::EW_W + 1)'(out_col_ff) >= (opm_pkg::EW_W + 1)'(eff_r)) &&
      ((opm_pkg::EW_W + 1)'(out_col_ff) + (opm_pkg::EW_W + 1)'(eff_r) <
       (opm_pkg::EW_W + 1)'(eff_w));
   assign status.walk_last  = wmid_ff && ((opm_pkg::RAD_W + 1)'(wj_ff) ==
                                          (opm_pkg::RAD_W + 1)'({eff_r, 1'b0}));
   assign status.out_free   = !rsp_valid_ff || rsp_ready;
   assign status.clear_last = (clr_ff == opm_pkg::BIN_W'(opm_pkg::BINS - 1));

   assign is_last = ((opm_pkg::EH_W)'(out_row_ff) + opm_pkg::EH_W'(1) == eff_h) &&
                    ((opm_pkg::EW_W)'(out_col_ff) + opm_pkg::EW_W'(1) == eff_w);
   assign restart  = csr_we || (cmd.load_out && is_last);
   assign px_write = cmd.accept && (req_data.kind == opm_pkg::KIND_PIXEL) && !frame_in_ff;

   // line store
   assign ls_we    = px_write;
   assign ls_waddr = opm_pkg::LS_AW'(32'(in_ring_ff) * opm_pkg::MAX_WIDTH + 32'(in_col_ff));
   assign ls_wdata = {req_data.in_index, req_data.in_blue, req_data.in_green, req_data.in_red};

   always_comb begin
      v_d = eff_r - wi_ff;
      priority if (wmid_ff) begin
         v_ring = out_ring_ff;
         v_col  = (CW + 1)'(out_col_ff) + (CW + 1)'(wj_ff) - (CW + 1)'(eff_r);
      end else if (wlow_ff) begin
         v_ring = opm_pkg::ring_add(out_ring_ff, v_d);
         v_col  = (CW + 1)'(out_col_ff) + (CW + 1)'(wj_ff) - (CW + 1)'(wi_ff);
      end else begin
         v_ring = opm_pkg::ring_sub(out_ring_ff, v_d);
         v_col  = (CW + 1)'(out_col_ff) + (CW + 1)'(wj_ff) - (CW + 1)'(wi_ff);
      end
      if (cmd.vote_rd) begin
         ls_raddr = opm_pkg::LS_AW'(32'(v_ring) * opm_pkg::MAX_WIDTH + 32'(v_col[CW-1:0]));
      end else begin
         ls_raddr = opm_pkg::LS_AW'(32'(out_ring_ff) * opm_pkg::MAX_WIDTH + 32'(out_col_ff));
      end
   end

   opm_ram #(.WIDTH(32), .DEPTH(opm_pkg::LS_DEPTH)) u_line_store (
      .clock      (clock),
      .wr_en      (ls_we),
      .wr_addr    (ls_waddr),
      .wr_data    (ls_wdata),
      .rd_addr    (ls_raddr),
      .rd_data_ff (ls_rdata)
   );

   // luminance of the fetched neighbour
   always_comb begin
      k_r = cfg_mode_ff ? opm_pkg::LI_R : opm_pkg::LT_R;
      k_g = cfg_mode_ff ? opm_pkg::LI_G : opm_pkg::LT_G;
      k_b = cfg_mode_ff ? opm_pkg::LI_B : opm_pkg::LT_B;
      luma_sum = 20'(ls_rdata[7:0]) * 20'(k_r) + 20'(ls_rdata[15:8]) * 20'(k_g) +
                 20'(ls_rdata[23:16]) * 20'(k_b);
   end

   // histogram
   assign h_next  = h_rdata + opm_pkg::CNT_W'(1);
   assign h_we    = cmd.hist_upd || cmd.clear_step;
   assign h_waddr = cmd.clear_step ? clr_ff : luma_ff;
   assign h_wdata = cmd.clear_step ? '0 : h_next;

   opm_ram #(.WIDTH(opm_pkg::CNT_W), .DEPTH(opm_pkg::BINS)) u_hist (
      .clock      (clock),
      .wr_en      (h_we),
      .wr_addr    (h_waddr),
      .wr_data    (h_wdata),
      .rd_addr    (luma_ff),
      .rd_data_ff (h_rdata)
   );

   // walk order: upper/lower alternate per column, ring by ring, then middle row
   always_comb begin
      wi_in   = wi_ff;
      wj_in   = wj_ff;
      wlow_in = wlow_ff;
      wmid_in = wmid_ff;
      priority if (cmd.walk_init) begin
         wi_in = '0; wj_in = '0; wlow_in = 1'b0; wmid_in = 1'b0;
      end else if (cmd.hist_upd) begin
         priority if (wmid_ff) begin
            wj_in = wj_ff + opm_pkg::WJ_W'(1);
         end else if (!wlow_ff) begin
            wlow_in = 1'b1;
         end else begin
            wlow_in = 1'b0;
            if ((opm_pkg::RAD_W + 1)'(wj_ff) == (opm_pkg::RAD_W + 1)'({wi_ff, 1'b0})) begin
               wj_in = '0;
               if (wi_ff == eff_r - opm_pkg::RAD_W'(1)) wmid_in = 1'b1;
               else wi_in = wi_ff + opm_pkg::RAD_W'(1);
            end else begin
               wj_in = wj_ff + opm_pkg::WJ_W'(1);
            end
         end
      end
   end

   // frame counters
   always_comb begin
      in_col_in   = in_col_ff;
      in_row_in   = in_row_ff;
      in_ring_in  = in_ring_ff;
      out_col_in  = out_col_ff;
      out_row_in  = out_row_ff;
      out_ring_in = out_ring_ff;
      gap_in      = gap_ff;
      frame_in_in = frame_in_ff;
      priority if (restart) begin
         in_col_in = '0; in_row_in = '0; in_ring_in = '0;
         out_col_in = '0; out_row_in = '0; out_ring_in = '0;
         gap_in = '0; frame_in_in = 1'b0;
      end else if (px_write) begin
         gap_in = gap_ff + opm_pkg::GAP_W'(1);
         if (opm_pkg::EW_W'(in_col_ff) + opm_pkg::EW_W'(1) >= eff_w) begin
            in_col_in = '0;
            if (opm_pkg::EH_W'(in_row_ff) + opm_pkg::EH_W'(1) >= eff_h) begin
               in_row_in = '0; in_ring_in = '0; frame_in_in = 1'b1;
            end else begin
               in_row_in  = in_row_ff + XW'(1);
               in_ring_in = opm_pkg::ring_add(in_ring_ff, opm_pkg::RAD_W'(1));
            end
         end else begin
            in_col_in = in_col_ff + CW'(1);
         end
      end else if (cmd.load_out) begin
         gap_in = gap_ff - opm_pkg::GAP_W'(1);
         if (opm_pkg::EW_W'(out_col_ff) + opm_pkg::EW_W'(1) >= eff_w) begin
            out_col_in  = '0;
            out_row_in  = out_row_ff + XW'(1);
            out_ring_in = opm_pkg::ring_add(out_ring_ff, opm_pkg::RAD_W'(1));
         end else begin
            out_col_in = out_col_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_w_ff     <= opm_pkg::CFG_W_W'(640);
         cfg_h_ff     <= opm_pkg::CFG_H_W'(480);
         cfg_r_ff     <= opm_pkg::CFG_R_W'(3);
         cfg_mode_ff  <= 1'b0;
         in_col_ff    <= '0;
         in_row_ff    <= '0;
         in_ring_ff   <= '0;
         out_col_ff   <= '0;
         out_row_ff   <= '0;
         out_ring_ff  <= '0;
         gap_ff       <= '0;
         frame_in_ff  <= 1'b0;
         wi_ff        <= '0;
         wj_ff        <= '0;
         wlow_ff      <= 1'b0;
         wmid_ff      <= 1'b0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (opm_pkg::csr_index_type'(csr_index))
               opm_pkg::CSR_IMAGE_WIDTH:  cfg_w_ff <= csr_wdata[opm_pkg::CFG_W_W-1:0];
               opm_pkg::CSR_IMAGE_HEIGHT: cfg_h_ff <= csr_wdata[opm_pkg::CFG_H_W-1:0];
               opm_pkg::CSR_WINDOW_RAD:   cfg_r_ff <= csr_wdata[opm_pkg::CFG_R_W-1:0];
               opm_pkg::CSR_COLOR_MODE:   cfg_mode_ff <= csr_wdata[0];
               default: ;
            endcase
         end
         in_col_ff   <= in_col_in;
         in_row_ff   <= in_row_in;
         in_ring_ff  <= in_ring_in;
         out_col_ff  <= out_col_in;
         out_row_ff  <= out_row_in;
         out_ring_ff <= out_ring_in;
         gap_ff      <= gap_in;
         frame_in_ff <= frame_in_in;
         wi_ff       <= wi_in;
         wj_ff       <= wj_in;
         wlow_ff     <= wlow_in;
         wmid_ff     <= wmid_in;
         if (cmd.clear_step) clr_ff <= clr_ff + opm_pkg::BIN_W'(1);
         if (cmd.load_out) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.vote_take) begin
         word_ff <= ls_rdata;
         luma_ff <= luma_sum[opm_pkg::LUMA_SHIFT +: opm_pkg::BIN_W];
      end
      if (cmd.walk_init) best_ff <= '0;
      if (cmd.centre_take) chosen_ff <= ls_rdata;
      if (cmd.hist_upd && (h_next > best_ff)) begin
         best_ff   <= h_next;
         chosen_ff <= word_ff;
      end
      if (cmd.load_out) begin
         rsp_ff.out_red    <= chosen_ff[7:0];
         rsp_ff.out_green  <= chosen_ff[15:8];
         rsp_ff.out_blue   <= chosen_ff[23:16];
         rsp_ff.out_index  <= cfg_mode_ff ? chosen_ff[31:24] : 8'd0;
         rsp_ff.frame_last <= is_last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== rtl/oil_paint_mode_filter_unit.sv =====
// Top level of the oil-paint mode filter.
// One transaction is taken at a time. After reset the 256 histogram bins are
// swept to zero before the first transaction is taken. A transaction that
// releases no result goes from decide back to idle; an edge pixel reads its
// centre pixel from the line store and loads it as the result. An interior
// pixel votes each of its 2r*r+2r+1 diamond neighbours through one line-store
// read port and one read-modify-write of the histogram memory, then sweeps
// the 256 histogram bins back to zero. The line store is not cleared after
// reset. Results wait in an output register, so a finished result does not
// stall the next input; a second result waits until the first is taken.
module oil_paint_mode_filter_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [opm_pkg::CSR_IW-1:0] csr_index,
   input  logic [opm_pkg::CSR_DW-1:0] csr_wdata,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  opm_pkg::req_type           req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output opm_pkg::rsp_type           rsp_data
);

   opm_pkg::cmd_type    cmd;
   opm_pkg::status_type status;

   opm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   opm_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

// ===== tb/tb_oil_paint_mode_filter_unit.sv =====
// Testbench for the oil-paint mode filter: directed and random frames against a predictor.
module tb_oil_paint_mode_filter_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SETTLE = 1300;
   localparam int STALL_LIMIT = 30000;
   localparam int ITEM_TARGET = 1650;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [opm_pkg::CSR_IW-1:0] csr_index = '0;
   logic [opm_pkg::CSR_DW-1:0] csr_wdata = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   opm_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   opm_pkg::rsp_type rsp_data;

   oil_paint_mode_filter_unit u_top (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   logic [31:0] line_mem [opm_pkg::RING * opm_pkg::MAX_WIDTH];
   int unsigned bin_cnt [opm_pkg::BINS];
   int unsigned reg_w = 640, reg_h = 480, reg_rad = 3, reg_mode = 0;
   int unsigned in_col, in_row, out_col, out_row;
   bit frame_full;
   opm_pkg::rsp_type expected_px [$];

   int errors, items_sent, results_seen, frames_done, interior_seen;
   int send_idle_pct, recv_idle_pct, quiet_cycles;

   task automatic report_mismatch(input string what);
      $display("ERROR t=%0t %s", $realtime, what);
      errors++;
   endtask

   function automatic int unsigned luma_of(logic [31:0] px);
      if (reg_mode != 0)
         return ((px[7:0] * 872 + px[15:8] * 2930 + px[23:16] * 296) >> 12) & 8'hff;
      return ((px[7:0] * 871 + px[15:8] * 2929 + px[23:16] * 295) >> 12) & 8'hff;
   endfunction

   function automatic logic [31:0] read_px(int unsigned row, int unsigned col);
      if (col >= opm_pkg::MAX_WIDTH) return '0;
      return line_mem[(row % opm_pkg::RING) * opm_pkg::MAX_WIDTH + col];
   endfunction

   function automatic logic [31:0] mode_pick(int unsigned r, int unsigned c, int unsigned rad);
      int unsigned best;
      logic [31:0] pick, nb;
      int unsigned k;
      best = 0;
      pick = read_px(r, c);
      foreach (bin_cnt[b]) bin_cnt[b] = 0;
      for (int i = 0; i < rad; i++) begin
         for (int j = 0; j < 2 * i + 1; j++) begin
            for (int s = 0; s < 2; s++) begin
               nb = read_px(s == 0 ? r - (rad - i) : r + (rad - i), c - i + j);
               k = luma_of(nb);
               bin_cnt[k]++;
               if (bin_cnt[k] > best) begin
                  best = bin_cnt[k];
                  pick = nb;
               end
            end
         end
      end
      for (int j = 0; j < 2 * rad + 1; j++) begin
         nb = read_px(r, c - rad + j);
         k = luma_of(nb);
         bin_cnt[k]++;
         if (bin_cnt[k] > best) begin
            best = bin_cnt[k];
            pick = nb;
         end
      end
      return pick;
   endfunction

   function automatic void restart_frame();
      in_col = 0; in_row = 0; out_col = 0; out_row = 0; frame_full = 0;
   endfunction

   function automatic void predict_transaction(opm_pkg::req_type t);
      int unsigned w, h, rad, got, nxt;
      bit inner, last;
      logic [31:0] px;
      opm_pkg::rsp_type e;
      w = reg_w < 1 ? 1 : (reg_w > opm_pkg::MAX_WIDTH ? opm_pkg::MAX_WIDTH : reg_w);
      h = reg_h < 1 ? 1 : (reg_h > opm_pkg::MAX_HEIGHT ? opm_pkg::MAX_HEIGHT : reg_h);
      rad = reg_rad < 2 ? 2 : (reg_rad > opm_pkg::MAX_RADIUS ? opm_pkg::MAX_RADIUS : reg_rad);
      if (t.kind == opm_pkg::KIND_PIXEL && !frame_full) begin
         if (in_col < opm_pkg::MAX_WIDTH)
            line_mem[(in_row % opm_pkg::RING) * opm_pkg::MAX_WIDTH + in_col] =
               {t.in_index, t.in_blue, t.in_green, t.in_red};
         in_col++;
         if (in_col >= w) begin
            in_col = 0;
            in_row++;
            if (in_row >= h) begin
               in_row = 0;
               frame_full = 1;
            end
         end
      end
      got = in_row * w + in_col;
      nxt = out_row * w + out_col;
      if (!frame_full && !(nxt + rad * w < got)) return;
      inner = out_row >= rad && out_row + rad < h && out_col >= rad && out_col + rad < w;
      px = inner ? mode_pick(out_row, out_col, rad) : read_px(out_row, out_col);
      if (inner) interior_seen++;
      last = out_row + 1 == h && out_col + 1 == w;
      e.out_red = px[7:0];
      e.out_green = px[15:8];
      e.out_blue = px[23:16];
      e.out_index = reg_mode != 0 ? px[31:24] : 8'h00;
      e.frame_last = last;
      expected_px.push_back(e);
      if (last) begin
         restart_frame();
         frames_done++;
      end else begin
         out_col++;
         if (out_col >= w) begin
            out_col = 0;
            out_row++;
         end
      end
   endfunction

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (expected_px.size() == 0) begin
            report_mismatch($sformatf("unexpected result %h", rsp_data));
         end else begin
            opm_pkg::rsp_type e;
            e = expected_px.pop_front();
            if (rsp_data.out_red !== e.out_red)
               report_mismatch($sformatf("red %h, want %h", rsp_data.out_red, e.out_red));
            if (rsp_data.out_green !== e.out_green)
               report_mismatch($sformatf("green %h, want %h", rsp_data.out_green, e.out_green));
            if (rsp_data.out_blue !== e.out_blue)
               report_mismatch($sformatf("blue %h, want %h", rsp_data.out_blue, e.out_blue));
            if (rsp_data.out_index !== e.out_index)
               report_mismatch($sformatf("index %h, want %h", rsp_data.out_index, e.out_index));
            if (rsp_data.frame_last !== e.frame_last)
               report_mismatch($sformatf("frame_last %b, want %b",
                                         rsp_data.frame_last, e.frame_last));
         end
      end
   end

   always @(negedge clock)
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);

   // watchdog on cycles with no transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("oil_paint_mode_filter_unit verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // entered and left at a falling edge; valid stays high afterwards
   task automatic send_item(input opm_pkg::req_type t);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         do @(negedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid = 1'b1;
      req_data = t;
      do @(posedge clock); while (!req_ready);
      predict_transaction(t);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_valid = 1'b0;
      while (expected_px.size() != 0) @(negedge clock);
   endtask

   task automatic settle_block();
      drain_results();
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_reg(input opm_pkg::csr_index_type idx, input int unsigned value);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = opm_pkg::CSR_DW'(value);
      @(negedge clock);
      csr_we = 1'b0;
      case (idx)
         opm_pkg::CSR_IMAGE_WIDTH:  reg_w = value & 11'h7ff;
         opm_pkg::CSR_IMAGE_HEIGHT: reg_h = value & 13'h1fff;
         opm_pkg::CSR_WINDOW_RAD:   reg_rad = value & 4'hf;
         opm_pkg::CSR_COLOR_MODE:   reg_mode = value & 1;
      endcase
      restart_frame();
   endtask

   task automatic set_geometry(input int unsigned w, h, rad, mode);
      settle_block();
      write_reg(opm_pkg::CSR_IMAGE_WIDTH, w);
      write_reg(opm_pkg::CSR_IMAGE_HEIGHT, h);
      write_reg(opm_pkg::CSR_WINDOW_RAD, rad);
      write_reg(opm_pkg::CSR_COLOR_MODE, mode);
   endtask

   function automatic opm_pkg::req_type make_pixel(input logic [7:0] r, g, b, idx);
      opm_pkg::req_type t;
      t.kind = opm_pkg::KIND_PIXEL;
      t.in_red = r; t.in_green = g; t.in_blue = b; t.in_index = idx;
      return t;
   endfunction

   function automatic opm_pkg::req_type make_drain();
      opm_pkg::req_type t;
      t = $bits(opm_pkg::req_type)'({$urandom, $urandom});
      t.kind = ~opm_pkg::KIND_PIXEL;
      return t;
   endfunction

   function automatic opm_pkg::req_type random_pixel(input logic [7:0] r, g, b, idx);
      return make_pixel(r, g, b, idx);
   endfunction

   // a few shades so that the histogram has clear winners and ties
   function automatic opm_pkg::req_type shade_pixel(input logic [31:0] shades [4]);
      logic [31:0] v;
      v = ($urandom_range(9) == 0) ? $urandom : shades[$urandom_range(3)];
      return make_pixel(v[7:0], v[15:8], v[23:16], v[31:24]);
   endfunction

   // one whole frame plus drains; optional mid-frame pause until all results are in
   task automatic run_frame(input bit pause_mid);
      logic [31:0] shades [4];
      int n;
      foreach (shades[i]) shades[i] = $urandom;
      n = 0;
      while (!frame_full) begin
         if ($urandom_range(99) < 8) send_item(make_drain());
         else send_item(shade_pixel(shades));
         n++;
         if (pause_mid && n == 20) drain_results();
      end
      while (frame_full) begin
         if ($urandom_range(99) < 5) send_item(shade_pixel(shades));
         else send_item(make_drain());
      end
   endtask

   task automatic test_directed_edges();
      // reset geometry: nothing released yet, so drains give nothing
      send_item(make_drain());
      send_item(make_drain());
      send_item(make_pixel(8'h00, 8'h00, 8'h00, 8'h00));
      send_item(make_pixel(8'hff, 8'hff, 8'hff, 8'hff));
      // zero width and height clamp to a single pixel frame
      set_geometry(0, 0, 0, 1);
      send_item(make_pixel(8'hff, 8'h00, 8'hff, 8'h5a));
      send_item(make_pixel(8'h00, 8'hff, 8'h00, 8'ha5));
      send_item(make_drain());
      // oversize width, height and radius clamp; frame abandoned part way
      set_geometry(2047, 8191, 15, 0);
      repeat (4) send_item(random_pixel(8'($urandom), 8'($urandom), 8'($urandom),
                                        8'($urandom)));
      set_geometry(1, 4096, 1, 1);
      repeat (5) send_item(random_pixel(8'($urandom), 8'($urandom), 8'($urandom),
                                        8'($urandom)));
      set_geometry(1024, 1, 2, 0);
      repeat (4) send_item(make_pixel(8'hff, 8'hff, 8'hff, 8'h00));
   endtask

   task automatic test_largest_window();
      set_geometry(22, 21, 10, 1);
      run_frame(0);
   endtask

   task automatic test_narrow_images();
      set_geometry(4, 6, 2, 0);
      run_frame(0);
      set_geometry(9, 3, 3, 1);
      run_frame(0);
   endtask

   task automatic test_random_frames(input int target);
      int unsigned rad, w, h;
      bit paused;
      paused = 0;
      while (items_sent < target) begin
         rad = ($urandom_range(7) == 0) ? $urandom_range(4, 10) : $urandom_range(2, 3);
         w = $urandom_range(2 * rad + 1, 2 * rad + 8);
         h = $urandom_range(2 * rad + 1, 2 * rad + 5);
         if (rad > 5) begin
            w = 2 * rad + $urandom_range(1, 2);
            h = 2 * rad + 1;
         end
         if ($urandom_range(9) == 0) h = $urandom_range(1, 2 * rad);
         set_geometry(w, h, rad, $urandom_range(1));
         run_frame(!paused && w * h > 30);
         if (w * h > 30) paused = 1;
      end
   endtask

   initial begin
      send_idle_pct = 28;
      recv_idle_pct = 53;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed_edges();
      test_narrow_images();
      test_random_frames(ITEM_TARGET / 3);
      send_idle_pct = 53;
      recv_idle_pct = 28;
      test_largest_window();
      test_random_frames(2 * ITEM_TARGET / 3);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_frames(ITEM_TARGET);
      settle_block();
      $display("covered %0d transactions, %0d results (%0d filtered), %0d complete frames",
               items_sent, results_seen, interior_seen, frames_done);
      $display("geometry clamps, abandoned frames, narrow images and radii 2 to 10");
      if (errors == 0 && expected_px.size() == 0) begin
         $display("oil_paint_mode_filter_unit verification clean");
      end else begin
         $display("oil_paint_mode_filter_unit verification failed");
      end
      $finish;
   end

endmodule
